### rtl/bes_pkg.sv
`timescale 1ns / 1ps

package bes_pkg;

  // Sizes of the edge store and of the source-node buckets.
  localparam int NODE_BITS    = 10;
  localparam int EDGE_DEPTH   = 1024;
  localparam int IDX_BITS     = $clog2(EDGE_DEPTH);
  localparam int CNT_BITS     = $clog2(EDGE_DEPTH + 1);
  localparam int BUCKET_NODES = 128;
  localparam int BUCKET_SHIFT = $clog2(BUCKET_NODES);
  localparam int NUM_BUCKETS  = ((1 << NODE_BITS) + BUCKET_NODES - 1) / BUCKET_NODES;
  localparam int BKT_BITS     = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int REL_BITS     = 2;
  localparam int MAX_MATCHES  = 63;
  localparam int MATCH_BITS   = $clog2(MAX_MATCHES + 1);

  // Request codes.
  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  // One stored edge.
  typedef struct packed {
    logic [NODE_BITS-1:0] src;
    logic [NODE_BITS-1:0] dst;
    logic [REL_BITS-1:0]  rel;
  } edge_entry_t;

  // Bounds of one bucket as read from the bucket table.
  typedef struct packed {
    logic                valid;
    logic [IDX_BITS-1:0] first;
    logic [IDX_BITS-1:0] last;
  } bkt_bounds_t;

  // Update request from the controller to the bucket table.
  typedef struct packed {
    logic                clr;
    logic                wr_en;
    logic [BKT_BITS-1:0] wr_bkt;
    logic [IDX_BITS-1:0] wr_idx;
  } bkt_update_t;

  // Bucket number of a node.
  function automatic logic [BKT_BITS-1:0] bucket_of(input logic [NODE_BITS-1:0] node);
    logic [NODE_BITS-1:0] shifted;
    shifted = node >> BUCKET_SHIFT;
    return shifted[BKT_BITS-1:0];
  endfunction

endpackage

### rtl/bucketed_edge_search_core.sv
`timescale 1ns / 1ps
// Clear and append transactions produce no result and leave busy low.
// A query of an empty bucket returns its end marker in the cycle after acceptance.
// A query of a non-empty bucket walks the edge memory at one edge per cycle;
// busy stays high through the scan, drain and finish states; the end marker comes last.
// Results cannot be stalled by the receiver.
// Synchronous reset empties every bucket and zeroes the edge count and last source.
module bucketed_edge_search_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    req_type,
  input  logic [bes_pkg::NODE_BITS-1:0] edge_src,
  input  logic [bes_pkg::NODE_BITS-1:0] edge_dst,
  input  logic [1:0]                    edge_rel,
  input  logic [bes_pkg::NODE_BITS-1:0] query_node,
  input  logic [1:0]                    query_rel,
  output logic                          strobe,
  output logic [bes_pkg::NODE_BITS-1:0] found_node,
  output logic                          end_of_list
);
  import bes_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t               state;
  logic [CNT_BITS-1:0]  edge_count;
  logic [NODE_BITS-1:0] last_source;
  logic [IDX_BITS-1:0]  ptr;
  logic [IDX_BITS-1:0]  scan_last;
  logic [NODE_BITS-1:0] q_node;
  logic [REL_BITS-1:0]  q_rel;
  logic [MATCH_BITS-1:0] n_match;
  logic                 rd_valid;

  logic                 accept;
  logic                 append_ok;
  logic                 hit;
  req_t                 req;
  bkt_update_t          bkt_upd;
  bkt_bounds_t          bounds;
  edge_entry_t          wr_entry;
  edge_entry_t          rd_entry;
  logic [BKT_BITS-1:0]  rd_bkt;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign req    = req_t'(req_type);

  // An append is kept only while there is room and the source order holds.
  assign append_ok = accept && (req == REQ_APPEND)
                  && (edge_count < CNT_BITS'(EDGE_DEPTH))
                  && ((edge_count == '0) || (edge_src >= last_source));

  assign wr_entry.src = edge_src;
  assign wr_entry.dst = edge_dst;
  assign wr_entry.rel = edge_rel;

  always_comb begin
    bkt_upd.clr    = accept && (req == REQ_CLEAR);
    bkt_upd.wr_en  = append_ok;
    bkt_upd.wr_bkt = bucket_of(edge_src);
    bkt_upd.wr_idx = edge_count[IDX_BITS-1:0];
  end

  assign rd_bkt = bucket_of(query_node);

  bes_bucket_tbl u_bucket_tbl (
    .clk    (clk),
    .rst    (rst),
    .upd    (bkt_upd),
    .rd_bkt (rd_bkt),
    .bounds (bounds)
  );

  bes_edge_ram u_edge_ram (
    .clk   (clk),
    .we    (append_ok),
    .waddr (edge_count[IDX_BITS-1:0]),
    .wdata (wr_entry),
    .re    (state == ST_SCAN),
    .raddr (ptr),
    .rdata (rd_entry)
  );

  // Match test on the edge read in the previous cycle.
  assign hit = rd_valid && (rd_entry.src == q_node) && (rd_entry.rel == q_rel)
            && (n_match < MATCH_BITS'(MAX_MATCHES));

  // Edge count and last source.
  always_ff @(posedge clk) begin
    if (rst || (accept && (req == REQ_CLEAR))) begin
      edge_count  <= '0;
      last_source <= '0;
    end else if (append_ok) begin
      edge_count  <= edge_count + 1'b1;
      last_source <= edge_src;
    end
  end

  // Query sequencer with registered result outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      rd_valid    <= 1'b0;
      strobe      <= 1'b0;
      end_of_list <= 1'b0;
      found_node  <= '0;
      n_match     <= '0;
    end else begin
      strobe      <= 1'b0;
      end_of_list <= 1'b0;
      rd_valid    <= (state == ST_SCAN);
      if (hit) begin
        strobe     <= 1'b1;
        found_node <= rd_entry.dst;
        n_match    <= n_match + 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (accept && (req == REQ_QUERY)) begin
            q_node  <= query_node;
            q_rel   <= query_rel;
            n_match <= '0;
            if (bounds.valid) begin
              ptr       <= bounds.first;
              scan_last <= bounds.last;
              state     <= ST_SCAN;
            end else begin
              strobe      <= 1'b1;
              end_of_list <= 1'b1;
              found_node  <= '0;
            end
          end
        end
        ST_SCAN: begin
          if (ptr == scan_last) begin
            state <= ST_DRAIN;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        ST_DRAIN: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          strobe      <= 1'b1;
          end_of_list <= 1'b1;
          found_node  <= '0;
          state       <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/bes_edge_ram.sv
`timescale 1ns / 1ps

module bes_edge_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [bes_pkg::IDX_BITS-1:0] waddr,
  input  bes_pkg::edge_entry_t        wdata,
  input  logic                        re,
  input  logic [bes_pkg::IDX_BITS-1:0] raddr,
  output bes_pkg::edge_entry_t        rdata
);
  import bes_pkg::*;

  edge_entry_t mem [EDGE_DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/bes_bucket_tbl.sv
`timescale 1ns / 1ps

module bes_bucket_tbl (
  input  logic                         clk,
  input  logic                         rst,
  input  bes_pkg::bkt_update_t         upd,
  input  logic [bes_pkg::BKT_BITS-1:0] rd_bkt,
  output bes_pkg::bkt_bounds_t         bounds
);
  import bes_pkg::*;

  logic [NUM_BUCKETS-1:0] valid;
  logic [IDX_BITS-1:0]    first [NUM_BUCKETS];
  logic [IDX_BITS-1:0]    last  [NUM_BUCKETS];

  // Valid bits: cleared by reset and by a clear transaction.
  always_ff @(posedge clk) begin
    if (rst || upd.clr) begin
      valid <= '0;
    end else if (upd.wr_en) begin
      valid[upd.wr_bkt] <= 1'b1;
    end
  end

  // First index is taken by the first edge of a bucket; last follows every append.
  always_ff @(posedge clk) begin
    if (upd.wr_en) begin
      if (!valid[upd.wr_bkt]) begin
        first[upd.wr_bkt] <= upd.wr_idx;
      end
      last[upd.wr_bkt] <= upd.wr_idx;
    end
  end

  // One read at the bucket the controller selects.
  always_comb begin
    bounds.valid = valid[rd_bkt];
    bounds.first = first[rd_bkt];
    bounds.last  = last[rd_bkt];
  end

endmodule
